// ===== design/swlm_pkg.sv =====
// ----------------------------------------------------------------------------
// swlm_pkg: shared types and constants for the label mode filter
// Label codes, class count and the command word that travels from the
// front part through the queue to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package swlm_pkg;

   // label codes
   typedef logic [2:0] label_type;

   localparam int        NUM_CLASSES  = 6;
   localparam label_type CODE_UNKNOWN = 3'd5;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // one classified item, as handed from front to back
   typedef struct packed {
      label_type label;         // incoming label, already saturated
      label_type old_label;     // label leaving the window (valid with remove)
      logic      remove;        // oldest label leaves the window
      logic      clear;         // start of sequence: counts go to zero first
      logic      zero_length;   // window length zero: output unknown
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/sliding_window_label_mode_filter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_label_mode_filter: mode filter over recent class labels
// Outputs the most frequent of the last window_length labels.
// ----------------------------------------------------------------------------
// The block takes one six-valued label per transfer and returns one smoothed
// label per transfer: the most frequent label among the last window_length
// labels, the current one included, with ties going to the lowest code.
// Codes 6 and 7 count as unknown (5); a window length of zero returns unknown;
// lengths above WINDOW_MAX act as WINDOW_MAX. A set start flag (req_tuser)
// empties the window before its label is counted. Throughput is one label per
// clock while rsp_tready stays high. rsp_tvalid rises once the label has passed
// the stage 1 register with the registered read of the label store, the
// command queue and the output register. The label store needs no clearing
// pass after reset. Write window_length only while no labels are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_label_mode_filter #(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration: window_length
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [6:0] csr_wdata,
   // input labels
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [2:0] raw_phase, [7:3] zero
   input  wire logic       req_tuser,    // [0] start_of_sequence
   // smoothed labels
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata     // [2:0] smoothed_phase, [7:3] zero
);

   localparam int FILL_W = $clog2(WINDOW_MAX + 1);

   logic                push, q_full, q_valid, pop;
   swlm_pkg::cmd_type   push_cmd, q_cmd;
   swlm_pkg::label_type smoothed_phase;

   // front: classify and address the label store
   swlm_front #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .raw_phase         (req_tdata[2:0]),
      .start_of_sequence (req_tuser),
      .q_full            (q_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // queue between the two halves
   swlm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // back: counts and vote
   swlm_back #(
      .WINDOW_MAX (WINDOW_MAX),
      .FILL_W     (FILL_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .smoothed_phase (smoothed_phase)
   );

   assign rsp_tdata = {5'b0, smoothed_phase};

   // checks
   a_result_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= swlm_pkg::CODE_UNKNOWN)
      else $error("result label out of range");

endmodule

`default_nettype wire

// ===== design/swlm_ram.sv =====
// ----------------------------------------------------------------------------
// swlm_ram: generic single-write, single-read RAM
// Registered read with enable; a read and a write to the same address in
// the same cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module swlm_ram #(
   parameter int WIDTH  = 3,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and read register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/swlm_front.sv =====
// ----------------------------------------------------------------------------
// swlm_front: input side of the label mode filter
// Holds the window length register, the ring pointers and the label store.
// Classifies each label (clear, remove oldest, zero length), writes it to
// the store and hands a command plus the leaving label to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module swlm_front #(
   parameter int WINDOW_MAX = 64,
   parameter int FILL_W     = $clog2(WINDOW_MAX + 1),
   parameter int HEAD_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [6:0]          csr_wdata,
   // incoming labels
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire swlm_pkg::label_type raw_phase,
   input  wire logic                start_of_sequence,
   // toward the queue
   input  wire logic                q_full,
   output logic                     push,
   output swlm_pkg::cmd_type        push_cmd
);

   localparam int CMP_W = (FILL_W > 7) ? FILL_W : 7;

   logic [6:0]          window_length_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [HEAD_W-1:0]   head_ff, head_in;
   logic                s1_valid_ff, s1_valid_in;
   swlm_pkg::label_type s1_label_ff;
   logic                s1_remove_ff, s1_clear_ff, s1_zero_ff;

   logic                accept;
   logic [CMP_W-1:0]    wl_ext;
   logic [FILL_W-1:0]   w_eff;
   logic                zero_length;
   logic [FILL_W-1:0]   cur_fill, fill_after;
   logic [HEAD_W-1:0]   cur_head, head_nx;
   logic                remove;
   logic [FILL_W:0]     slot_sum, slot_red;
   logic [HEAD_W-1:0]   slot;
   swlm_pkg::label_type label_sat, old_label;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
      end else if (csr_valid) begin
         window_length_ff <= csr_wdata;
      end
   end

   // window length saturated to the store depth
   always_comb begin
      wl_ext = CMP_W'(window_length_ff);
      if (wl_ext > CMP_W'(WINDOW_MAX)) begin
         w_eff = FILL_W'(WINDOW_MAX);
      end else begin
         w_eff = FILL_W'(wl_ext);
      end
   end

   assign zero_length = (w_eff == '0);
   assign label_sat   = (raw_phase > swlm_pkg::CODE_UNKNOWN) ? swlm_pkg::CODE_UNKNOWN
                                                             : raw_phase;

   // stage 1 moves on when the queue has room
   assign push      = s1_valid_ff && !q_full;
   assign req_ready = !s1_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;

   // ring pointer arithmetic for this label
   always_comb begin
      cur_fill = start_of_sequence ? '0 : fill_ff;
      cur_head = start_of_sequence ? '0 : head_ff;
      remove   = !zero_length && (cur_fill != '0) && (cur_fill >= w_eff);
      if (remove) begin
         head_nx    = (cur_head == HEAD_W'(WINDOW_MAX - 1)) ? '0 : cur_head + 1'b1;
         fill_after = cur_fill - 1'b1;
      end else begin
         head_nx    = cur_head;
         fill_after = cur_fill;
      end
      slot_sum = (FILL_W + 1)'(head_nx) + (FILL_W + 1)'(fill_after);
      if (slot_sum >= (FILL_W + 1)'(WINDOW_MAX)) begin
         slot_red = slot_sum - (FILL_W + 1)'(WINDOW_MAX);
      end else begin
         slot_red = slot_sum;
      end
      slot = HEAD_W'(slot_red);
   end

   // pointer next state
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (zero_length) begin
            head_in = cur_head;
            fill_in = cur_fill;
         end else begin
            head_in = head_nx;
            fill_in = fill_after + 1'b1;
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         head_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage 1 payload, lines up with the store read data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_label_ff  <= label_sat;
         s1_remove_ff <= remove;
         s1_clear_ff  <= start_of_sequence;
         s1_zero_ff   <= zero_length;
      end
   end

   // label store: new label written, oldest label read
   swlm_ram #(
      .WIDTH (3),
      .DEPTH (WINDOW_MAX)
   ) u_label_store (
      .clock   (clock),
      .wr_en   (accept && !zero_length),
      .wr_addr (slot),
      .wr_data (label_sat),
      .rd_en   (accept && remove),
      .rd_addr (cur_head),
      .rd_data (old_label)
   );

   always_comb begin
      push_cmd.label       = s1_label_ff;
      push_cmd.old_label   = old_label;
      push_cmd.remove      = s1_remove_ff;
      push_cmd.clear       = s1_clear_ff;
      push_cmd.zero_length = s1_zero_ff;
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_MAX))
      else $error("window fill above store depth");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && start_of_sequence |=> fill_ff <= FILL_W'(1))
      else $error("start of sequence did not empty the window");

endmodule

`default_nettype wire

// ===== design/swlm_queue.sv =====
// ----------------------------------------------------------------------------
// swlm_queue: short command queue between front and back
// Small circular buffer of classified items so either side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module swlm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire swlm_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output swlm_pkg::cmd_type      pop_cmd
);

   localparam int DEPTH = swlm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   swlm_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and count next state
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== design/swlm_back.sv =====
// ----------------------------------------------------------------------------
// swlm_back: count update and vote
// Applies one queued command to the per-class counts, votes over the new
// counts (ties to the lowest code) and holds the result in the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module swlm_back #(
   parameter int WINDOW_MAX = 64,
   parameter int FILL_W     = $clog2(WINDOW_MAX + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // from the queue
   input  wire logic              q_valid,
   input  wire swlm_pkg::cmd_type q_cmd,
   output logic                   pop,
   // results
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output swlm_pkg::label_type    smoothed_phase
);

   localparam int NC    = swlm_pkg::NUM_CLASSES;
   localparam int SUM_W = FILL_W + 3;

   logic [FILL_W-1:0]   counts_ff [NC];
   logic [FILL_W-1:0]   counts_in [NC];
   logic                rsp_valid_ff, rsp_valid_in;
   swlm_pkg::label_type result_ff, result_in;
   swlm_pkg::label_type best;
   logic [FILL_W-1:0]   best_count;
   logic [SUM_W-1:0]    count_sum;

   // take a command when the output register is free or being drained
   assign pop          = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   // count update for the popped command
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         counts_in[c] = counts_ff[c];
         if (pop) begin
            if (q_cmd.clear) begin
               counts_in[c] = '0;
            end
            if (q_cmd.remove && (q_cmd.old_label == 3'(c)) && (counts_in[c] != '0)) begin
               counts_in[c] = counts_in[c] - 1'b1;
            end
            if (!q_cmd.zero_length && (q_cmd.label == 3'(c))) begin
               counts_in[c] = counts_in[c] + 1'b1;
            end
         end
      end
   end

   // vote over the updated counts, strictly greater keeps the lower code
   always_comb begin
      best       = swlm_pkg::CODE_UNKNOWN;
      best_count = '0;
      for (int c = 0; c < NC; c++) begin
         if (counts_in[c] > best_count) begin
            best_count = counts_in[c];
            best       = 3'(c);
         end
      end
      result_in = q_cmd.zero_length ? swlm_pkg::CODE_UNKNOWN : best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            counts_ff[c] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NC; c++) begin
            counts_ff[c] <= counts_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign smoothed_phase = result_ff;

   // total of held labels
   always_comb begin
      count_sum = '0;
      for (int c = 0; c < NC; c++) begin
         count_sum = count_sum + SUM_W'(counts_ff[c]);
      end
   end

   // checks
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      count_sum <= SUM_W'(WINDOW_MAX))
      else $error("class counts exceed store depth");

   a_push_counted: assert property (@(posedge clock) disable iff (reset)
      pop && !q_cmd.zero_length |=> count_sum != '0)
      else $error("pushed label left no count");

endmodule

`default_nettype wire
